@@ rtl/hspm_pkg.sv @@
// Package with shared types, constants and the hash mixing round for the sparse page memory.
package hspm_pkg;

  localparam int unsigned DefBuckets   = 64;
  localparam int unsigned DefPageWords = 1024;
  localparam logic [31:0] HashMult     = 32'h045d9f3b;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SWAP  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  // Back-part sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_DATA,
    ST_OUT
  } back_state_t;

  // One mixing round: fold the high half into the low half.
  function automatic logic [31:0] fold16(input logic [31:0] x);
    fold16 = (x >> 16) ^ x;
  endfunction

endpackage

@@ rtl/hspm_front.sv @@
// Front part: accepts transactions and computes the page hash over a short pipeline.
module hspm_front #(
  parameter int unsigned BUCKETS    = hspm_pkg::DefBuckets,
  parameter int unsigned PAGE_WORDS = hspm_pkg::DefPageWords
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hspm_pkg::op_t               in_op,
  input  logic [31:0]                 in_addr,
  input  logic [31:0]                 in_wdata,
  output logic                        q_valid,
  input  logic                        q_ready,
  output hspm_pkg::op_t               q_op,
  output logic [31:0]                 q_addr,
  output logic [31:0]                 q_wdata,
  output logic [$clog2(BUCKETS)-1:0]  q_start
);
  import hspm_pkg::*;

  localparam int unsigned OffW = $clog2(PAGE_WORDS);
  localparam int unsigned IdxW = $clog2(BUCKETS);

  // Stage registers: 0 captures input, 1 first product, 2 second product.
  logic [2:0]  vld;
  op_t         op0, op1, op2;
  logic [31:0] ad0, ad1, ad2;
  logic [31:0] wd0, wd1, wd2;
  logic [31:0] h1, h2;
  logic [31:0] key0;
  logic [31:0] h2f;
  logic        adv;

  // Only one transaction at a time is hashed; the last stage holds the finished hash until it is taken.
  assign adv      = !vld[2] || q_ready;
  assign in_ready = (vld == 3'b000);
  assign key0     = ad0 & ~32'(PAGE_WORDS - 1);
  assign h2f      = fold16(h2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (in_valid && in_ready) vld[0] <= 1'b1;
      else if (vld[0]) vld[0] <= 1'b0;
      vld[1] <= vld[0];
      if (vld[1]) vld[2] <= 1'b1;
      else if (q_ready) vld[2] <= 1'b0;
    end
  end

  // Payload moves with the valid bits.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op0 <= in_op;
      ad0 <= in_addr;
      wd0 <= in_wdata;
    end
    op1 <= op0;
    ad1 <= ad0;
    wd1 <= wd0;
    h1  <= fold16(key0) * HashMult;
    if (vld[1]) begin
      op2 <= op1;
      ad2 <= ad1;
      wd2 <= wd1;
      h2  <= fold16(h1) * HashMult;
    end
  end

  assign q_valid = vld[2] && adv;
  assign q_op    = op2;
  assign q_addr  = ad2;
  assign q_wdata = wd2;
  assign q_start = h2f[IdxW-1:0];

  logic unused_off;
  assign unused_off = ^OffW;
endmodule

@@ rtl/hspm_back.sv @@
// Back part: probes the bucket table, accesses the data store, holds the result.
module hspm_back #(
  parameter int unsigned BUCKETS    = hspm_pkg::DefBuckets,
  parameter int unsigned PAGE_WORDS = hspm_pkg::DefPageWords
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  hspm_pkg::op_t               q_op,
  input  logic [31:0]                 q_addr,
  input  logic [31:0]                 q_wdata,
  input  logic [$clog2(BUCKETS)-1:0]  q_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_rdata,
  output logic                        out_status,
  output logic                        out_alloc
);
  import hspm_pkg::*;

  localparam int unsigned IdxW   = $clog2(BUCKETS);
  localparam int unsigned OffW   = $clog2(PAGE_WORDS);
  localparam int unsigned PageW  = 32 - OffW;
  localparam int unsigned Depth  = BUCKETS * PAGE_WORDS;
  localparam int unsigned CellW  = IdxW + OffW;
  localparam int unsigned CntW   = IdxW + 1;

  // Bucket table and data store.
  logic [PageW-1:0] tag_mem [BUCKETS];
  logic [31:0]      data_mem [Depth];
  logic [BUCKETS-1:0] used;
  logic [CellW-1:0] clr_ptr;
  logic             clearing;

  back_state_t state, state_next;
  op_t         op;
  logic [31:0] addr, wdata;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] tries;
  logic [PageW-1:0] tag_rd;
  logic        used_rd;
  logic [31:0] data_rd;
  logic        alloc, full;
  logic [31:0] rdata_r;
  logic        status_r, alloc_r;

  logic [PageW-1:0] page;
  logic [CellW-1:0] word_sel;
  logic             hit, miss_free, do_write;

  assign page      = addr[31:OffW];
  assign word_sel  = {idx, addr[OffW-1:0]};
  assign hit       = used_rd && (tag_rd == page);
  assign miss_free = !used_rd;
  assign do_write  = (op == OP_WRITE) || (op == OP_SWAP);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid && !clearing) state_next = ST_PROBE;
      ST_PROBE: state_next = ST_CHECK;
      ST_CHECK: begin
        if (hit || miss_free) state_next = ST_DATA;
        else if (tries == CntW'(BUCKETS)) state_next = ST_OUT;
        else state_next = ST_PROBE;
      end
      ST_DATA:  state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    q_ready   = (state == ST_IDLE) && !clearing;
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= BUCKETS'(1);
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_ptr <= clr_ptr + 1'b1;
        if (clr_ptr == CellW'(Depth - 1)) clearing <= 1'b0;
      end
      if (state == ST_CHECK && miss_free) used[idx] <= 1'b1;
    end
  end

  // Table reads and allocation.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_mem[0] <= '0;
    end else if (state == ST_CHECK && miss_free) begin
      tag_mem[idx] <= page;
    end
    tag_rd  <= tag_mem[idx];
    used_rd <= used[idx];
  end

  // Data store: clearing pass, then one write per write or swap transaction; the read port runs every cycle.
  always_ff @(posedge clk) begin
    if (clearing) data_mem[clr_ptr] <= '0;
    else if (state == ST_DATA && do_write) data_mem[word_sel] <= wdata;
    data_rd <= data_mem[word_sel];
  end

  // Transaction registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op    <= q_op;
        addr  <= q_addr;
        wdata <= q_wdata;
        idx   <= q_start;
        tries <= CntW'(1);
        alloc <= 1'b0;
        full  <= 1'b0;
      end
      ST_CHECK: begin
        if (miss_free) alloc <= 1'b1;
        else if (!hit) begin
          idx   <= idx + 1'b1;
          tries <= tries + 1'b1;
          if (tries == CntW'(BUCKETS)) full <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register; the data read issued in CHECK is ready in DATA.
  always_ff @(posedge clk) begin
    if (state == ST_DATA) begin
      rdata_r  <= (op == OP_WRITE) ? 32'd0 : data_rd;
      status_r <= 1'b0;
      alloc_r  <= alloc;
    end else if (state == ST_CHECK && !hit && !miss_free && tries == CntW'(BUCKETS)) begin
      rdata_r  <= 32'd0;
      status_r <= 1'b1;
      alloc_r  <= 1'b0;
    end
  end

  assign out_rdata  = rdata_r;
  assign out_status = status_r;
  assign out_alloc  = alloc_r;

  logic unused_full;
  assign unused_full = full;
endmodule

@@ rtl/hashed_sparse_page_memory.sv @@
// Top level of the hashed sparse page memory.
// Sparse 32-bit word memory: pages are found through a hashed bucket table with
// linear probing and allocated on first touch. A transaction passes through hashing
// in the front part, a probe and a check state per probed bucket, a data state and
// a result state. The back part works on one transaction at a time and idles
// between transactions, while the front part hashes the next one. A miss with
// every bucket used probes all BUCKETS buckets and returns status 1, read data 0
// and writes nothing. After reset the data store is cleared one word a cycle, all
// BUCKETS*PAGE_WORDS words, before the first transaction is worked.
module hashed_sparse_page_memory #(
  parameter int unsigned BUCKETS    = hspm_pkg::DefBuckets,
  parameter int unsigned PAGE_WORDS = hspm_pkg::DefPageWords
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // op[1:0], word_addr[33:2], write_data[65:34], zeros
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // read_data[31:0], status[32], page_allocated[33], zeros
);
  import hspm_pkg::*;

  logic        q_valid, q_ready;
  op_t         q_op;
  logic [31:0] q_addr, q_wdata;
  logic [$clog2(BUCKETS)-1:0] q_start;
  logic [31:0] rdata;
  logic        status, alloc;
  logic [5:0]  unused_pad;

  assign unused_pad = s_axis_tdata[71:66];

  hspm_front #(.BUCKETS(BUCKETS), .PAGE_WORDS(PAGE_WORDS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(op_t'(s_axis_tdata[1:0])), .in_addr(s_axis_tdata[33:2]),
    .in_wdata(s_axis_tdata[65:34]),
    .q_valid, .q_ready, .q_op, .q_addr, .q_wdata, .q_start
  );

  hspm_back #(.BUCKETS(BUCKETS), .PAGE_WORDS(PAGE_WORDS)) u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_op, .q_addr, .q_wdata, .q_start,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_rdata(rdata), .out_status(status), .out_alloc(alloc)
  );

  assign m_axis_tdata = {6'd0, alloc, status, rdata};
endmodule

@@ dv/tb_hashed_sparse_page_memory.sv @@
// Self-checking testbench for the hashed sparse page memory.
module tb_hashed_sparse_page_memory;
  import hspm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NB = DefBuckets;
  localparam int unsigned NW = DefPageWords;
  localparam int unsigned WATCHDOG_LIMIT = 4 * NB * NW;

  typedef struct packed {
    logic [31:0] write_data;
    logic [31:0] word_addr;
    op_t         op;
  } access_t;

  typedef struct packed {
    logic        page_allocated;
    logic        status;
    logic [31:0] read_data;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  hashed_sparse_page_memory dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Shadow copy of the page table and data store.
  logic        bucket_used [NB];
  logic [21:0] bucket_page [NB];
  logic [31:0] shadow_mem  [NB*NW];

  access_t pending_access [$];
  reply_t  expected_reply [$];
  int      error_count = 0;
  int      full_count = 0;
  int      alloc_count = 0;
  int      reply_count = 0;
  bit      stall_sink = 0;
  bit      calm = 0;
  int      idle_cycles = 0;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic logic [31:0] page_hash(input logic [31:0] x);
    logic [31:0] v;
    v = ((x >> 16) ^ x) * 32'h045d9f3b;
    v = ((v >> 16) ^ v) * 32'h045d9f3b;
    return (v >> 16) ^ v;
  endfunction

  // Work out the reply of one access and update the shadow state.
  function automatic reply_t predict_access(input access_t a);
    reply_t      r;
    logic [31:0] offs, key;
    logic [21:0] pnum;
    int unsigned b;
    bit          hit, fresh;
    logic [31:0] prior;
    offs = a.word_addr % NW;
    pnum = a.word_addr / NW;
    key  = a.word_addr - offs;
    b    = page_hash(key) % NB;
    hit  = 0;
    fresh = 0;
    for (int n = 0; n < NB; n++) begin
      if (!bucket_used[b]) begin
        bucket_used[b] = 1;
        bucket_page[b] = pnum;
        hit = 1;
        fresh = 1;
        break;
      end
      if (bucket_page[b] == pnum) begin
        hit = 1;
        break;
      end
      b = (b + 1) % NB;
    end
    r = '0;
    if (!hit) begin
      r.status = 1'b1;
      return r;
    end
    prior = shadow_mem[b*NW + offs];
    if (a.op == OP_WRITE || a.op == OP_SWAP) shadow_mem[b*NW + offs] = a.write_data;
    r.read_data = (a.op == OP_WRITE) ? 32'd0 : prior;
    r.page_allocated = fresh;
    return r;
  endfunction

  function automatic access_t make_access(input op_t o, input logic [31:0] ad,
                                          input logic [31:0] wd);
    access_t a;
    a.op = o;
    a.word_addr = ad;
    a.write_data = wd;
    return a;
  endfunction

  // Driver: presents pending accesses with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reply.push_back(predict_access(s_axis_tdata[65:0]));
        void'(pending_access.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready) || !s_axis_tvalid) begin
        if (s_axis_tvalid && !s_axis_tready) begin
          // Hold the current transaction.
        end else if (pending_access.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
                     (calm || $urandom_range(99) >= 31)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, pending_access[0]};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and sink: random backpressure, compares each reply with the oldest one.
  always @(posedge clk) begin
    reply_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[33:0];
        reply_count++;
        if (expected_reply.size() == 0) begin
          $error("unexpected reply %h", got);
          error_count++;
        end else begin
          want = expected_reply.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data expected %h actual %h", want.read_data, got.read_data);
            error_count++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            error_count++;
          end
          if (got.page_allocated !== want.page_allocated) begin
            $error("page_allocated expected %0d actual %0d",
                   want.page_allocated, got.page_allocated);
            error_count++;
          end
          if (want.status) full_count++;
          if (want.page_allocated) alloc_count++;
        end
      end
      m_axis_tready <= !stall_sink && (calm || $urandom_range(99) >= 31);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Long sink stall once replies flow, so the input side backs up and stalls.
  initial begin
    wait (reply_count >= 20);
    stall_sink = 1;
    repeat (300) @(posedge clk);
    stall_sink = 0;
  end

  // Addresses drawn mostly from a handful of pages so hits are common.
  function automatic logic [31:0] pick_addr(input logic [21:0] page_pool [8]);
    int unsigned k;
    k = $urandom_range(9);
    if (k < 8) return {page_pool[$urandom_range(7)], 10'(($urandom_range(3) == 0) ?
                       $urandom : $urandom_range(15))};
    return $urandom;
  endfunction

  initial begin
    logic [21:0] pool [8];
    op_t         o;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < NB; i++) begin
      bucket_used[i] = 0;
      bucket_page[i] = '0;
    end
    for (int i = 0; i < NB*NW; i++) shadow_mem[i] = '0;
    bucket_used[page_hash(32'd0) % NB] = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every op code, reserved op as read, write read-back.
    pending_access.push_back(make_access(OP_READ,  32'd0, 32'd0));
    pending_access.push_back(make_access(OP_WRITE, 32'd0, 32'hffffffff));
    pending_access.push_back(make_access(OP_READ,  32'd0, 32'd0));
    pending_access.push_back(make_access(OP_SWAP,  32'd0, 32'h5a5a5a5a));
    pending_access.push_back(make_access(OP_RSVD,  32'd0, 32'hffffffff));
    pending_access.push_back(make_access(OP_WRITE, 32'hffffffff, 32'ha5a5a5a5));
    pending_access.push_back(make_access(OP_READ,  32'hffffffff, 32'd0));
    pending_access.push_back(make_access(OP_SWAP,  32'hfffffc00, 32'h12345678));
    pending_access.push_back(make_access(OP_READ,  32'h000003ff, 32'd0));
    pending_access.push_back(make_access(OP_WRITE, 32'h00000400, 32'h0));
    pending_access.push_back(make_access(OP_SWAP,  32'h80000000, 32'h80000001));
    pending_access.push_back(make_access(OP_RSVD,  32'h80000000, 32'd7));

    // Random phase; the sink stall lands inside it.
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    for (int i = 0; i < 500; i++) begin
      o = op_t'($urandom_range(3));
      pending_access.push_back(make_access(o, pick_addr(pool), $urandom));
    end

    // Fill the table with fresh pages until it overflows, then keep hitting it.
    wait (pending_access.size() < 50);
    for (int i = 0; i < 120; i++)
      pending_access.push_back(make_access(OP_WRITE, $urandom, $urandom));
    wait (pending_access.size() < 50);
    calm = 1;
    for (int i = 0; i < 200; i++) begin
      o = op_t'($urandom_range(3));
      pending_access.push_back(make_access(o, pick_addr(pool), $urandom));
    end
    wait (pending_access.size() < 50);
    calm = 0;
    for (int i = 0; i < 400; i++) begin
      o = op_t'($urandom_range(3));
      pending_access.push_back(make_access(o, ($urandom_range(1) == 0) ?
                               pick_addr(pool) : $urandom, $urandom));
    end

    wait (pending_access.size() == 0 && !s_axis_tvalid);
    wait (expected_reply.size() == 0);
    repeat (50) @(posedge clk);
    $display("Checked %0d replies: %0d page allocations, %0d table-full misses.",
             reply_count, alloc_count, full_count);
    $display("Covered read, write, swap and reserved ops with stalls on both sides.");
    if (error_count == 0 && expected_reply.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hspm_pkg.sv
rtl/hspm_front.sv
rtl/hspm_back.sv
rtl/hashed_sparse_page_memory.sv
dv/tb_hashed_sparse_page_memory.sv
